@@ sv/skt_pkg.sv @@
// Shared constants, types and the key order function for the sorted key table.
`default_nettype none

package skt_pkg;

  // Table geometry and payload widths.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;

  // Index width addresses one cell; count width also holds the full count.
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Readout tree: cells are ORed in groups, then the groups are ORed.
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // Sign bit of a key, flipped to turn a signed order into an unsigned one.
  localparam logic [KEY_W-1:0] KEY_TOP = KEY_W'(1) << (KEY_W - 1);

  // Operation codes of a request.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  // Status codes of a result.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  // What the row of cells does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_COMPARE = 2'd1,
    CELL_INSERT  = 2'd2,
    CELL_REMOVE  = 2'd3
  } cell_op_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e          op;
    logic              signed_order;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] datum;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  rd_pos;
  } cell_cmd_t;

  // True when key a orders below key b.
  function automatic logic key_less(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b,
                                    input logic sgn);
    logic [KEY_W-1:0] ax;
    logic [KEY_W-1:0] bx;
    ax = sgn ? (a ^ KEY_TOP) : a;
    bx = sgn ? (b ^ KEY_TOP) : b;
    return ax < bx;
  endfunction

endpackage

`default_nettype wire

@@ sv/skt_cell.sv @@
// One table cell: holds a key and datum pair, shifts with its neighbors, compares and reads out.
`default_nettype none

module skt_cell (
  input  logic                      clk_i,
  input  skt_pkg::cell_cmd_t        cmd_i,
  input  logic [skt_pkg::IDX_W-1:0] cell_idx_i,
  input  logic [skt_pkg::KEY_W-1:0]  lo_key_i,
  input  logic [skt_pkg::DATA_W-1:0] lo_datum_i,
  input  logic [skt_pkg::KEY_W-1:0]  hi_key_i,
  input  logic [skt_pkg::DATA_W-1:0] hi_datum_i,
  output logic [skt_pkg::KEY_W-1:0]  key_o,
  output logic [skt_pkg::DATA_W-1:0] datum_o,
  output logic                      lt_o,
  output logic                      eq_o,
  output logic [skt_pkg::KEY_W-1:0]  rd_key_o,
  output logic [skt_pkg::DATA_W-1:0] rd_datum_o
);
  import skt_pkg::*;

  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] datum_q;
  logic              lt_q;
  logic              eq_q;
  logic [CNT_W-1:0]  idx_ext;
  logic              at_pos;
  logic              take_lower;
  logic              take_upper;
  logic              rd_sel;

  // Where this cell stands relative to the operation's position.
  assign idx_ext    = CNT_W'(cell_idx_i);
  assign at_pos     = (idx_ext == cmd_i.pos);
  assign take_lower = (idx_ext > cmd_i.pos) && (idx_ext <= cmd_i.count);
  assign take_upper = (idx_ext >= cmd_i.pos) && ((idx_ext + CNT_W'(1)) < cmd_i.count);
  assign rd_sel     = (cell_idx_i == cmd_i.rd_pos);

  // Entry and compare flags; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CELL_INSERT: begin
        if (at_pos) begin
          key_q   <= cmd_i.key;
          datum_q <= cmd_i.datum;
        end else if (take_lower) begin
          key_q   <= lo_key_i;
          datum_q <= lo_datum_i;
        end
      end
      CELL_REMOVE: begin
        if (take_upper) begin
          key_q   <= hi_key_i;
          datum_q <= hi_datum_i;
        end
      end
      CELL_COMPARE: begin
        lt_q <= key_less(key_q, cmd_i.key, cmd_i.signed_order);
        eq_q <= (key_q == cmd_i.key);
      end
      default: begin
      end
    endcase
  end

  assign key_o      = key_q;
  assign datum_o    = datum_q;
  assign lt_o       = lt_q;
  assign eq_o       = eq_q;

  // Masked readout feeds the OR tree; only the selected cell shows its pair.
  assign rd_key_o   = rd_sel ? key_q : '0;
  assign rd_datum_o = rd_sel ? datum_q : '0;

endmodule

`default_nettype wire

@@ sv/sorted_key_table.sv @@
// Top level of the sorted key table: controller, search sequencer and the row of cells.
//
// Usage: a request carries mode, key, datum_in and index on the input channel
// (valid/ready); each request gives exactly one result on the output channel
// (valid/ready) with status, datum_out, key_out, position and entry_count.
// The table keeps up to CAPACITY pairs in key order in a row of cells; insert
// and remove shift all affected cells by one place. One request is in flight
// at a time. A read by index below the count passes the readout states RD1
// and RD2; a read past the count goes straight to the hand-off. Insert,
// remove and lookup compare in every cell, then take one halving step at a
// time (at most 7 with CAPACITY = 64) plus a closing step when the key is
// missing, an apply step and an output load; a lookup hit adds RD1 and RD2
// for the readout OR tree. The next request can be taken in the same cycle as
// the result appears. The halving search runs over the registered compare
// flags. A new request is taken as soon as the controller is idle, even while
// the previous result still waits in the output register; if the receiver
// stalls, the next result holds in the controller until the output register
// frees. Reset empties the table (count zero) and selects unsigned key order.
// The order register is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce this.
`default_nettype none

module sorted_key_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] datum_in_i,
  input  logic [5:0]  index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] datum_out_o,
  output logic [31:0] key_out_o,
  output logic [6:0]  position_o,
  output logic [6:0]  entry_count_o
);
  import skt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CMP    = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_APPLY  = 7'b0001000,
    S_RD1    = 7'b0010000,
    S_RD2    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic              order_q;
  logic [CNT_W-1:0]  count_q, count_d;
  mode_e             mode_q, mode_d;
  logic [KEY_W-1:0]  req_key_q, req_key_d;
  logic [DATA_W-1:0] req_datum_q, req_datum_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              hit_q, hit_d;
  status_e           res_status_q, res_status_d;
  logic [KEY_W-1:0]  res_key_q, res_key_d;
  logic [DATA_W-1:0] res_datum_q, res_datum_d;
  cell_op_e          cell_op;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [DATA_W-1:0] out_datum_q;
  logic [CNT_W-1:0]  out_pos_q;
  logic [CNT_W-1:0]  out_count_q;

  cell_cmd_t         cmd;
  logic [KEY_W-1:0]  cell_key   [CAPACITY];
  logic [DATA_W-1:0] cell_datum [CAPACITY];
  logic [KEY_W-1:0]  rd_key     [CAPACITY];
  logic [DATA_W-1:0] rd_datum   [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;

  logic [KEY_W-1:0]  grp_key_d   [NUM_GRP];
  logic [DATA_W-1:0] grp_datum_d [NUM_GRP];
  logic [KEY_W-1:0]  grp_key_q   [NUM_GRP];
  logic [DATA_W-1:0] grp_datum_q [NUM_GRP];
  logic [KEY_W-1:0]  tree_key;
  logic [DATA_W-1:0] tree_datum;

  logic [CNT_W-1:0]  mid;
  logic [IDX_W-1:0]  mid_idx;
  logic              in_fire;
  logic              out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Probe point of the current halving step.
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign mid_idx = mid[IDX_W-1:0];

  // Command broadcast to the row of cells.
  always_comb begin
    cmd.op           = cell_op;
    cmd.signed_order = order_q;
    cmd.key          = req_key_q;
    cmd.datum        = req_datum_q;
    cmd.pos          = pos_q;
    cmd.count        = count_q;
    cmd.rd_pos       = pos_q[IDX_W-1:0];
  end

  // Row of cells, each wired to its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]  lo_key;
    logic [DATA_W-1:0] lo_datum;
    logic [KEY_W-1:0]  hi_key;
    logic [DATA_W-1:0] hi_datum;

    if (i == 0) begin : g_first
      assign lo_key   = cell_key[i];
      assign lo_datum = cell_datum[i];
    end else begin : g_lower
      assign lo_key   = cell_key[i-1];
      assign lo_datum = cell_datum[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign hi_key   = cell_key[i];
      assign hi_datum = cell_datum[i];
    end else begin : g_upper
      assign hi_key   = cell_key[i+1];
      assign hi_datum = cell_datum[i+1];
    end

    skt_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .cell_idx_i (IDX_W'(i)),
      .lo_key_i   (lo_key),
      .lo_datum_i (lo_datum),
      .hi_key_i   (hi_key),
      .hi_datum_i (hi_datum),
      .key_o      (cell_key[i]),
      .datum_o    (cell_datum[i]),
      .lt_o       (lt_vec[i]),
      .eq_o       (eq_vec[i]),
      .rd_key_o   (rd_key[i]),
      .rd_datum_o (rd_datum[i])
    );
  end

  // First level of the readout tree: OR within each group of cells.
  always_comb begin
    int unsigned c;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_key_d[g]   = '0;
      grp_datum_d[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        c = g * GRP_SIZE + j;
        if (c < CAPACITY) begin
          grp_key_d[g]   = grp_key_d[g] | rd_key[c];
          grp_datum_d[g] = grp_datum_d[g] | rd_datum[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_key_q[g]   <= grp_key_d[g];
      grp_datum_q[g] <= grp_datum_d[g];
    end
  end

  // Second level of the readout tree: OR of the group registers.
  always_comb begin
    tree_key   = '0;
    tree_datum = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      tree_key   = tree_key | grp_key_q[g];
      tree_datum = tree_datum | grp_datum_q[g];
    end
  end

  // Controller: latch, compare, halving search, apply, readout, hand-off.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    mode_d       = mode_q;
    req_key_d    = req_key_q;
    req_datum_d  = req_datum_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pos_d        = pos_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_datum_d  = res_datum_q;
    cell_op      = CELL_HOLD;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d       = mode_e'(mode_i);
          req_key_d    = key_i[KEY_W-1:0];
          req_datum_d  = datum_in_i[DATA_W-1:0];
          lo_d         = '0;
          hi_d         = count_q;
          hit_d        = 1'b0;
          res_status_d = ST_OK;
          res_key_d    = '0;
          res_datum_d  = '0;
          if (mode_e'(mode_i) == MODE_READ) begin
            pos_d = CNT_W'(index_i);
            if (CNT_W'(index_i) < count_q) begin
              state_d = S_RD1;
            end else begin
              res_status_d = ST_RANGE;
              state_d      = S_DONE;
            end
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        cell_op = CELL_COMPARE;
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          if (eq_vec[mid_idx]) begin
            pos_d   = mid;
            hit_d   = 1'b1;
            state_d = S_APPLY;
          end else if (lt_vec[mid_idx]) begin
            lo_d = mid + CNT_W'(1);
          end else begin
            hi_d = mid;
          end
        end else begin
          pos_d   = lo_q;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        state_d = S_DONE;
        case (mode_q)
          MODE_INSERT: begin
            if (hit_q) begin
              res_status_d = ST_PRESENT;
            end else if (count_q >= CNT_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              cell_op = CELL_INSERT;
              count_d = count_q + CNT_W'(1);
            end
          end
          MODE_REMOVE: begin
            if (!hit_q) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              cell_op = CELL_REMOVE;
              count_d = count_q - CNT_W'(1);
            end
          end
          MODE_LOOKUP: begin
            if (!hit_q) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              state_d = S_RD1;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD1: begin
        state_d = S_RD2;
      end
      S_RD2: begin
        res_datum_d = tree_datum;
        if (mode_q == MODE_READ) begin
          res_key_d = tree_key;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      order_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    req_key_q    <= req_key_d;
    req_datum_q  <= req_datum_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    pos_q        <= pos_d;
    hit_q        <= hit_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_datum_q  <= res_datum_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_datum_q  <= res_datum_q;
      out_pos_q    <= pos_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = 3'(out_status_q);
  assign datum_out_o   = 32'(out_datum_q);
  assign key_out_o     = 32'(out_key_q);
  assign position_o    = 7'(out_pos_q);
  assign entry_count_o = 7'(out_count_q);

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count moves only in the apply step, and then by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_APPLY) &&
      ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
    else $error("entry count changed outside an insert or remove");

  // The search window stays inside the stored entries.
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (lo_q <= hi_q) && (hi_q <= count_q))
    else $error("search window out of range");

  // A new result appears only as the controller hands one off.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised without a finished request");

  // A stalled result is never overwritten.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_pos_q) &&
      $stable(out_datum_q) && $stable(out_count_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
